### rtl/core/mfa_pkg.sv
// ----------------------------------------------------------------------------
// Mixed fraction ALU package
// Shared types, codes and constants for the mixed fraction ALU.
// ----------------------------------------------------------------------------
package mfa_pkg;

	localparam int WORD_BITS_DEF = 32;

	typedef enum logic [2:0] {
		FN_ADD = 3'd0,
		FN_SUB = 3'd1,
		FN_GT  = 3'd2,
		FN_GE  = 3'd3,
		FN_EQ  = 3'd4,
		FN_RED = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_NEGATIVE = 2'd3
	} status_t;

	// Sequencer steps.
	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_GCD,
		S_DIV1,
		S_DIV2,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_FINISH,
		S_DONE
	} state_t;

	// Commands to the shared divider.
	typedef struct packed {
		logic start;
	} div_ctl_t;

endpackage

### rtl/core/mfa_divider.sv
// ----------------------------------------------------------------------------
// Mixed fraction ALU divider
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
module mfa_divider #(
	parameter int WORD_BITS = mfa_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mfa_pkg::div_ctl_t    ctl,
	input  logic [WORD_BITS-1:0] dividend,
	input  logic [WORD_BITS-1:0] divisor,
	output logic                 done,
	output logic [WORD_BITS-1:0] quotient,
	output logic [WORD_BITS-1:0] remainder
);
	import mfa_pkg::*;

	localparam int CW = $clog2(WORD_BITS + 1);

	logic [WORD_BITS-1:0] quo_q;
	logic [WORD_BITS-1:0] rem_q;
	logic [WORD_BITS-1:0] dvs_q;
	logic [CW-1:0]        cnt_q;
	logic                 run_q;
	logic [WORD_BITS:0]   trial;

	assign trial = {rem_q, quo_q[WORD_BITS-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.start) begin
			run_q <= 1'b1;
			cnt_q <= CW'(WORD_BITS);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			if (!trial[WORD_BITS]) begin
				rem_q <= trial[WORD_BITS-1:0];
				quo_q <= {quo_q[WORD_BITS-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[WORD_BITS-2:0], quo_q[WORD_BITS-1]};
				quo_q <= {quo_q[WORD_BITS-2:0], 1'b0};
			end
		end
	end

	assign done      = run_q && (cnt_q == CW'(1)) ? 1'b0 : (!run_q && !ctl.start);
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### rtl/core/mixed_fraction_alu_top.sv
// ----------------------------------------------------------------------------
// Mixed fraction ALU
// Add, subtract, compare and reduce on non-negative mixed fractions.
// ----------------------------------------------------------------------------
// Sequence: one pass through the shared divider for each Euclid GCD step; the
// GCD takes up to about 1.44*WORD_BITS passes in the worst case, typically a
// handful, then two more divisions follow.
// Throughput: one transfer at a time; busy stays high until done pulses.
// Reset: arst_n clears the sequencer and done asynchronously.
// The receiver cannot stall: done marks the result for exactly one cycle.
module mixed_fraction_alu_top #(
	parameter int WORD_BITS = mfa_pkg::WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [31:0] left_integer,
	input  logic [31:0] left_numerator,
	input  logic [31:0] left_denominator,
	input  logic [31:0] right_integer,
	input  logic [31:0] right_numerator,
	input  logic [31:0] right_denominator,
	output logic        done,
	output logic [31:0] sum_integer,
	output logic [31:0] sum_numerator,
	output logic [31:0] sum_denominator,
	output logic        compare_true,
	output logic [1:0]  status
);
	import mfa_pkg::*;

	localparam int W = WORD_BITS;

	state_t state_q, state_d;

	// Operand registers, trimmed to the working word.
	logic [2:0]   fn_q;
	logic [W-1:0] li_q, ln_q, ld_q, ri_q, rn_q, rd_q;
	// Euclid working pair and results of the scaling step.
	logic [W-1:0] ga_q, gb_q;
	logic [W-1:0] q1_q, q2_q;
	logic [2*W-1:0] lnum_q, rnum_q, lcd_q;

	// Output registers.
	logic [31:0] oi_q, on_q, od_q;
	logic        cmp_q;
	logic [1:0]  st_q;
	logic        done_q;

	// Shared divider.
	div_ctl_t     dctl;
	logic [W-1:0] d_dividend, d_divisor, d_quo, d_rem;
	logic         d_done;

	mfa_divider #(.WORD_BITS(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (dctl),
		.dividend (d_dividend),
		.divisor  (d_divisor),
		.done     (d_done),
		.quotient (d_quo),
		.remainder(d_rem)
	);

	// The divider is idle in the cycle after it finished; we launch a pass on
	// entry to a dividing step, and after each Euclid pass, by tracking whether a pass is pending.
	logic pend_q;

	logic is_red, bad_left, bad_right, bad;
	assign is_red    = fn_q == FN_RED;
	assign bad_left  = (ld_q == '0) || (ln_q >= ld_q);
	assign bad_right = (rd_q == '0) || (rn_q >= rd_q);
	assign bad       = (fn_q > FN_RED) || bad_left || (!is_red && bad_right);

	// The one shared multiplier, a W x W product registered at its use.
	logic [W-1:0]   m_a, m_b;
	logic [2*W-1:0] m_p;
	assign m_p = m_a * m_b;

	always_comb begin
		m_a = ln_q;
		m_b = q1_q;
		unique case (state_q)
			S_MUL2:  begin m_a = rn_q; m_b = q2_q; end
			S_MUL3:  begin m_a = q2_q; m_b = rd_q; end
			default: begin m_a = ln_q; m_b = q1_q; end
		endcase
	end

	// Divider operands follow the step.
	always_comb begin
		d_dividend = ga_q;
		d_divisor  = gb_q;
		unique case (state_q)
			S_DIV1:  begin
				d_dividend = is_red ? ln_q : rd_q;
				d_divisor  = ga_q;
			end
			S_DIV2:  begin
				d_dividend = ld_q;
				d_divisor  = ga_q;
			end
			default: begin d_dividend = ga_q; d_divisor = gb_q; end
		endcase
	end

	logic div_step;
	assign div_step = (state_q == S_GCD && gb_q != '0) || state_q == S_DIV1 ||
		state_q == S_DIV2;
	assign dctl.start = div_step && pend_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (start) state_d = S_CHECK;
			S_CHECK:  state_d = bad ? S_DONE : S_GCD;
			S_GCD:    if (gb_q == '0) state_d = S_DIV1;
			S_DIV1:   if (!pend_q && d_done) state_d = S_DIV2;
			S_DIV2:   if (!pend_q && d_done) state_d = is_red ? S_DONE : S_MUL1;
			S_MUL1:   state_d = S_MUL2;
			S_MUL2:   state_d = S_MUL3;
			S_MUL3:   state_d = S_FINISH;
			S_FINISH: state_d = S_DONE;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == S_DONE;
			if (state_d != state_q && (state_d == S_GCD || state_d == S_DIV1 ||
				state_d == S_DIV2)) begin
				pend_q <= 1'b1;
			end else if (dctl.start) begin
				pend_q <= 1'b0;
			end else if (state_q == S_GCD && !pend_q && d_done) begin
				pend_q <= 1'b1;
			end
		end
	end

	// Datapath.
	logic [2*W:0] fsum, isum;
	logic         fcarry, lt, feq, fgt;
	assign fsum   = {1'b0, lnum_q} + {1'b0, rnum_q};
	assign fcarry = fsum >= {1'b0, lcd_q};
	assign isum   = (2*W+1)'(li_q) + (2*W+1)'(ri_q) + (2*W+1)'(fcarry);
	assign feq    = lnum_q == rnum_q;
	assign fgt    = lnum_q > rnum_q;
	assign lt     = (li_q < ri_q) || (li_q == ri_q && lnum_q < rnum_q);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					fn_q <= func;
					li_q <= left_integer[W-1:0];
					ln_q <= left_numerator[W-1:0];
					ld_q <= left_denominator[W-1:0];
					ri_q <= right_integer[W-1:0];
					rn_q <= right_numerator[W-1:0];
					rd_q <= right_denominator[W-1:0];
				end
			end
			S_CHECK: begin
				ga_q  <= is_red ? ln_q : ld_q;
				gb_q  <= is_red ? ld_q : rd_q;
				oi_q  <= '0;
				on_q  <= '0;
				od_q  <= '0;
				cmp_q <= 1'b0;
				st_q  <= bad ? ST_INVALID : ST_OK;
			end
			S_GCD: begin
				if (!pend_q && d_done) begin
					ga_q <= gb_q;
					gb_q <= d_rem;
				end
			end
			S_DIV1: if (!pend_q && d_done) q1_q <= d_quo;
			S_DIV2: begin
				if (!pend_q && d_done) begin
					q2_q <= d_quo;
					if (is_red) begin
						oi_q <= 32'(li_q);
						on_q <= 32'(q1_q);
						od_q <= 32'(d_quo);
					end
				end
			end
			S_MUL1: lnum_q <= m_p;
			S_MUL2: rnum_q <= m_p;
			S_MUL3: lcd_q  <= m_p;
			S_FINISH: begin
				unique case (fn_q)
					FN_ADD: begin
						if (lcd_q[2*W-1:W] != '0 || isum[2*W:W] != '0) begin
							st_q <= ST_OVERFLOW;
						end else begin
							oi_q <= 32'(isum[W-1:0]);
							on_q <= 32'(fcarry ? fsum - {1'b0, lcd_q} : fsum);
							od_q <= 32'(lcd_q[W-1:0]);
						end
					end
					FN_SUB: begin
						if (lcd_q[2*W-1:W] != '0) begin
							st_q <= ST_OVERFLOW;
						end else if (lt) begin
							st_q <= ST_NEGATIVE;
						end else if (!(rnum_q > lnum_q)) begin
							oi_q <= 32'(li_q - ri_q);
							on_q <= 32'(lnum_q - rnum_q);
							od_q <= 32'(lcd_q[W-1:0]);
						end else begin
							oi_q <= 32'(li_q - ri_q - 1'b1);
							on_q <= 32'(lnum_q + lcd_q - rnum_q);
							od_q <= 32'(lcd_q[W-1:0]);
						end
					end
					FN_GT:   cmp_q <= (li_q != ri_q) ? (li_q > ri_q) : fgt;
					FN_GE:   cmp_q <= (li_q != ri_q) ? (li_q > ri_q) : (fgt || feq);
					default: cmp_q <= (li_q == ri_q) && feq;
				endcase
			end
			default: ;
		endcase
	end

	assign busy            = state_q != S_IDLE;
	assign done            = done_q;
	assign sum_integer     = oi_q;
	assign sum_numerator   = on_q;
	assign sum_denominator = od_q;
	assign compare_true    = cmp_q;
	assign status          = st_q;

	// A result transfer follows the last sequencer step.
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_DONE) else $error("done without final step");
	// Busy does not drop without a result; no transfer is accepted while one is in work.
	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (busy || done)) else $error("busy dropped without result");
	// A flagged status carries no compare outcome.
	a_cmp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && compare_true |-> status == ST_OK) else $error("compare on error");

endmodule

### tb/mixed_fraction_alu_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mixed fraction ALU testbench
// Drives add, subtract, compare and reduce commands through the start/busy
// handshake. A short directed table comes first, then random commands. Every
// result is checked field by field against a predictor inside this module.
// ----------------------------------------------------------------------------
module mixed_fraction_alu_top_tb;

	import mfa_pkg::*;

	localparam int W = WORD_BITS_DEF;
	localparam int RANDOM_CMDS = 2000;
	// Each command can take about 50 divider passes in the worst case; a command
	// averages well under that, so this limit is generous.
	localparam longint CYCLE_LIMIT = 64'd12000000;
	localparam int DRAIN_CYCLES = 3000;

	// One command and the answer that the block should give for it.
	typedef struct {
		logic [2:0]  fn;
		logic [31:0] li, ln, ld, ri, rn, rd;
	} cmd_t;

	typedef struct {
		logic [31:0] oi, on, od;
		logic        cmp;
		logic [1:0]  st;
	} answer_t;

	// A directed row carries an optional typed-in answer.
	typedef struct {
		cmd_t    c;
		bit      typed;
		answer_t a;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  func;
	logic [31:0] left_integer, left_numerator, left_denominator;
	logic [31:0] right_integer, right_numerator, right_denominator;
	logic        done;
	logic [31:0] sum_integer, sum_numerator, sum_denominator;
	logic        compare_true;
	logic [1:0]  status;

	answer_t pending_answers[$];
	int      mismatches;
	longint  cycles;
	int      results_seen;
	int      cmds_sent;
	int      status_seen[4];
	row_t    directed_rows[$];

	mixed_fraction_alu_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.left_integer(left_integer), .left_numerator(left_numerator),
		.left_denominator(left_denominator), .right_integer(right_integer),
		.right_numerator(right_numerator), .right_denominator(right_denominator),
		.done(done), .sum_integer(sum_integer), .sum_numerator(sum_numerator),
		.sum_denominator(sum_denominator), .compare_true(compare_true),
		.status(status)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Euclid on 64-bit values, enough for any pair of 32-bit denominators.
	function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
		logic [63:0] t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	// Works out the exact answer for one command.
	function automatic answer_t fraction_answer(cmd_t c);
		answer_t     a;
		logic [63:0] wmask, li, ln, ld, ri, rn, rd, g, ls, rs, lnum, rnum, lcd;
		logic [63:0] f, i;
		bit          r;
		a = '{default: '0};
		wmask = (64'd1 << W) - 1;
		li = c.li & wmask;
		ln = c.ln & wmask;
		ld = c.ld & wmask;
		ri = c.ri & wmask;
		rn = c.rn & wmask;
		rd = c.rd & wmask;
		a.st = ST_OK;
		if (c.fn == FN_RED) begin
			if (ld == 0 || ln >= ld) begin
				a.st = ST_INVALID;
			end else begin
				g = gcd64(ln, ld);
				a.oi = li[31:0];
				a.on = 32'(ln / g);
				a.od = 32'(ld / g);
			end
		end else if (c.fn > FN_RED) begin
			a.st = ST_INVALID;
		end else if (ld == 0 || ln >= ld || rd == 0 || rn >= rd) begin
			a.st = ST_INVALID;
		end else begin
			g = gcd64(ld, rd);
			ls = rd / g;
			rs = ld / g;
			lnum = ln * ls;
			rnum = rn * rs;
			lcd = rs * rd;
			if (c.fn == FN_ADD || c.fn == FN_SUB) begin
				if (lcd > wmask) begin
					a.st = ST_OVERFLOW;
				end else if (c.fn == FN_ADD) begin
					f = lnum + rnum;
					i = li + ri;
					if (f >= lcd) begin
						f = f - lcd;
						i = i + 1;
					end
					if (i > wmask) begin
						a.st = ST_OVERFLOW;
					end else begin
						a.oi = i[31:0];
						a.on = f[31:0];
						a.od = lcd[31:0];
					end
				end else if (li < ri || (li == ri && lnum < rnum)) begin
					a.st = ST_NEGATIVE;
				end else if (lnum >= rnum) begin
					a.oi = 32'(li - ri);
					a.on = 32'(lnum - rnum);
					a.od = lcd[31:0];
				end else begin
					a.oi = 32'(li - ri - 1);
					a.on = 32'(lnum + lcd - rnum);
					a.od = lcd[31:0];
				end
			end else begin
				if (li != ri)
					r = (c.fn != FN_EQ) && (li > ri);
				else if (c.fn == FN_GT)
					r = lnum > rnum;
				else if (c.fn == FN_GE)
					r = lnum >= rnum;
				else
					r = lnum == rnum;
				a.cmp = r;
			end
		end
		return a;
	endfunction

	// Picks a 32-bit value, biased toward the ends of the range.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 3);
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			2: return $urandom_range(1, 64);
			3: return $urandom_range(1, 70000);
			default: return $urandom;
		endcase
	endfunction

	// A denominator from a small set of shapes: small ones share factors often,
	// which exercises both a short and a long GCD.
	function automatic logic [31:0] pick_den();
		case ($urandom_range(0, 4))
			0: return $urandom_range(1, 12);
			1: return $urandom_range(1, 1000);
			2: return $urandom_range(1, 65535);
			default: return pick_word();
		endcase
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		c.fn = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(FN_ADD, FN_RED));
		c.ld = pick_den();
		c.rd = pick_den();
		// Most operands are well formed, a few break the numerator rule.
		c.ln = (c.ld == 0 || $urandom_range(0, 15) == 0) ? pick_word()
			: $urandom_range(0, c.ld - 1);
		c.rn = (c.rd == 0 || $urandom_range(0, 15) == 0) ? pick_word()
			: $urandom_range(0, c.rd - 1);
		c.li = pick_word();
		// Equal integer parts push the compares and subtracts onto the fractions.
		c.ri = ($urandom_range(0, 2) == 0) ? c.li : pick_word();
		if ($urandom_range(0, 5) == 0) begin
			c.rn = c.ln;
			c.rd = c.ld;
		end
		return c;
	endfunction

	// Random gap before a command: often none, mostly short, now and then long.
	task automatic idle_gap();
		int n;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: n = 0;
			9: n = $urandom_range(20, 120);
			default: n = $urandom_range(1, 4);
		endcase
		repeat (n) @(posedge clk);
	endtask

	// Presents one command and holds it until the block takes it. The transfer
	// happens at the first rising edge that sees start high and busy low. The
	// block is busy in the cycle after a transfer, so start is dropped there.
	task automatic send_cmd(cmd_t c);
		func <= c.fn;
		left_integer <= c.li;
		left_numerator <= c.ln;
		left_denominator <= c.ld;
		right_integer <= c.ri;
		right_numerator <= c.rn;
		right_denominator <= c.rd;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		pending_answers.push_back(fraction_answer(c));
		cmds_sent++;
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on result %0d: %s got %0h expected %0h",
				results_seen, what, got, want);
	endtask

	// Result monitor: done is sampled at the edge that ends its cycle.
	always @(posedge clk) begin
		answer_t w;
		if (arst_n && done) begin
			results_seen++;
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing outstanding", results_seen);
			end else begin
				w = pending_answers.pop_front();
				status_seen[status]++;
				if (sum_integer !== w.oi)
					note_mismatch("sum_integer", sum_integer, w.oi);
				if (sum_numerator !== w.on)
					note_mismatch("sum_numerator", sum_numerator, w.on);
				if (sum_denominator !== w.od)
					note_mismatch("sum_denominator", sum_denominator, w.od);
				if (compare_true !== w.cmp)
					note_mismatch("compare_true", 32'(compare_true), 32'(w.cmp));
				if (status !== w.st)
					note_mismatch("status", 32'(status), 32'(w.st));
			end
		end
	end

	// Watchdog on a cycle counter.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_answers.size());
			$display("mixed_fraction_alu_top_tb NOT OK");
			$finish;
		end
	end

	// Adds a directed row; the answer is only typed in where it is obvious.
	task automatic add_row(logic [2:0] fn, logic [31:0] li, ln, ld, ri, rn, rd,
			bit typed = 0, logic [31:0] oi = 0, on = 0, od = 0,
			logic cmp = 0, logic [1:0] st = ST_OK);
		row_t r;
		r.c = '{fn, li, ln, ld, ri, rn, rd};
		r.typed = typed;
		r.a = '{oi, on, od, cmp, st};
		directed_rows.push_back(r);
	endtask

	task automatic build_table();
		logic [31:0] m;
		m = 32'hFFFF_FFFF;
		// Plain add with a common denominator, and one with a carry.
		add_row(FN_ADD, 1, 1, 4, 2, 1, 4, 1, 3, 2, 4, 0, ST_OK);
		add_row(FN_ADD, 0, 3, 4, 0, 3, 4, 1, 1, 2, 4, 0, ST_OK);
		add_row(FN_ADD, 5, 1, 6, 7, 3, 10);
		// Integer sum beyond the word, with and without the carry causing it.
		add_row(FN_ADD, m, 0, 1, 1, 0, 1, 1, 0, 0, 0, 0, ST_OVERFLOW);
		add_row(FN_ADD, m, 1, 2, 0, 1, 2, 1, 0, 0, 0, 0, ST_OVERFLOW);
		// Least common denominator beyond the word.
		add_row(FN_ADD, 0, 0, 32'hFFFF_FFFB, 0, 0, 32'hFFFF_FFFD,
			1, 0, 0, 0, 0, ST_OVERFLOW);
		add_row(FN_SUB, 0, 0, 65536, 0, 0, 65537, 1, 0, 0, 0, 0, ST_OVERFLOW);
		// Largest operands that still fit.
		add_row(FN_ADD, m - 1, m - 1, m, 0, m - 1, m);
		// Subtract with and without a borrow, and a negative difference.
		add_row(FN_SUB, 3, 3, 4, 1, 1, 4, 1, 2, 2, 4, 0, ST_OK);
		add_row(FN_SUB, 3, 1, 4, 1, 3, 4, 1, 1, 2, 4, 0, ST_OK);
		add_row(FN_SUB, 1, 1, 3, 2, 0, 5, 1, 0, 0, 0, 0, ST_NEGATIVE);
		add_row(FN_SUB, 2, 1, 3, 2, 1, 2, 1, 0, 0, 0, 0, ST_NEGATIVE);
		// Invalid operands: zero denominator, numerator not below denominator.
		add_row(FN_ADD, 1, 0, 0, 1, 0, 1, 1, 0, 0, 0, 0, ST_INVALID);
		add_row(FN_GT, 1, 0, 1, 1, 5, 5, 1, 0, 0, 0, 0, ST_INVALID);
		add_row(FN_RED, 9, m, m, 0, 0, 0, 1, 0, 0, 0, 0, ST_INVALID);
		// Reduce ignores a broken right operand; zero numerator gives 0/1.
		add_row(FN_RED, 7, 6, 8, 0, 9, 0, 1, 7, 3, 4, 0, ST_OK);
		add_row(FN_RED, m, 0, m, m, m, m, 1, m, 0, 1, 0, ST_OK);
		// Unused function codes.
		add_row(3'd6, 0, 0, 1, 0, 0, 1, 1, 0, 0, 0, 0, ST_INVALID);
		add_row(3'd7, m, m, m, m, m, m, 1, 0, 0, 0, 0, ST_INVALID);
		// Compares decided by the integer parts, then by the fractions.
		add_row(FN_GT, 2, 0, 1, 1, 0, 1, 1, 0, 0, 0, 1, ST_OK);
		add_row(FN_EQ, 2, 0, 1, 1, 0, 1, 1, 0, 0, 0, 0, ST_OK);
		add_row(FN_GE, 4, 1, 2, 4, 2, 4, 1, 0, 0, 0, 1, ST_OK);
		add_row(FN_GT, 4, 1, 2, 4, 2, 4, 1, 0, 0, 0, 0, ST_OK);
		add_row(FN_EQ, m, m - 1, m, m, m - 2, m - 1);
		add_row(FN_GE, 0, 0, 1, 0, 1, m);
	endtask

	initial begin
		cmd_t    c;
		answer_t a;
		arst_n = 1'b0;
		start = 1'b0;
		func = '0;
		left_integer = '0;
		left_numerator = '0;
		left_denominator = '0;
		right_integer = '0;
		right_numerator = '0;
		right_denominator = '0;
		mismatches = 0;
		cycles = 0;
		results_seen = 0;
		cmds_sent = 0;
		status_seen = '{0, 0, 0, 0};
		build_table();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: typed answers must agree with the predictor too.
		foreach (directed_rows[k]) begin
			c = directed_rows[k].c;
			if (directed_rows[k].typed) begin
				a = fraction_answer(c);
				if (a.oi !== directed_rows[k].a.oi || a.on !== directed_rows[k].a.on ||
					a.od !== directed_rows[k].a.od || a.cmp !== directed_rows[k].a.cmp ||
					a.st !== directed_rows[k].a.st) begin
					mismatches++;
					$display("directed row %0d: table answer disagrees with predictor", k);
				end
			end
			idle_gap();
			send_cmd(c);
		end

		for (int n = 0; n < RANDOM_CMDS; n++) begin
			idle_gap();
			send_cmd(random_cmd());
		end

		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d commands in %0d cycles; status ok/invalid/overflow/negative:",
			cmds_sent, cycles);
		$display("  %0d / %0d / %0d / %0d, %0d mismatches", status_seen[0],
			status_seen[1], status_seen[2], status_seen[3], mismatches);
		if (mismatches == 0 && pending_answers.size() == 0)
			$display("mixed_fraction_alu_top_tb OK");
		else
			$display("mixed_fraction_alu_top_tb NOT OK");
		$finish;
	end

endmodule
